@@ sv/mcqe_pkg.sv @@
// ----------------------------------------------------------------------------
// mcqe_pkg
// Shared types, codes and helpers for the multiple circular queue engine.
// ----------------------------------------------------------------------------
package mcqe_pkg;

  // Default sizes for the top level's parameters.
  localparam int MEM_DEPTH_DEF  = 256;
  localparam int MAX_QUEUES_DEF = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int QID_W      = 3;
  localparam int QCOUNT_W   = 4;
  localparam int SLOTS_W    = 9;
  localparam int OFFSET_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Legal segment sizes.
  localparam logic [SLOTS_W-1:0] SLOTS_MIN = 9'd2;
  localparam logic [SLOTS_W-1:0] SLOTS_MAX = 9'd256;

  // Register reset values.
  localparam logic [QCOUNT_W-1:0] QCOUNT_RST = 4'd1;
  localparam logic [SLOTS_W-1:0]  SLOTS_RST  = 9'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS       = 2'd1;

  // Operation codes.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Advance an offset by one, wrapping at the segment size.
  function automatic logic [OFFSET_W-1:0] wrap_next(input logic [OFFSET_W-1:0] off,
                                                    input logic [SLOTS_W-1:0]  slots);
    logic [SLOTS_W-1:0] n;
    n = {1'b0, off} + 9'd1;
    return (n >= slots) ? '0 : n[OFFSET_W-1:0];
  endfunction

endpackage

@@ sv/mcqe_in_if.sv @@
// ----------------------------------------------------------------------------
// mcqe_in_if
// Request channel: one queue operation per word.
// ----------------------------------------------------------------------------
interface mcqe_in_if #(
  parameter int DATA_WIDTH = mcqe_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [mcqe_pkg::QID_W-1:0]   queue_id;
  logic [DATA_WIDTH-1:0]        data_in;

  modport source (output valid, output func, output queue_id, output data_in,
                  input ready);
  modport sink   (input valid, input func, input queue_id, input data_in,
                  output ready);
endinterface

@@ sv/mcqe_out_if.sv @@
// ----------------------------------------------------------------------------
// mcqe_out_if
// Response channel: status and dequeued data, one word per request.
// ----------------------------------------------------------------------------
interface mcqe_out_if #(
  parameter int DATA_WIDTH = mcqe_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  mcqe_pkg::status_t     status;
  logic [DATA_WIDTH-1:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

@@ sv/mcqe_slot_ram.sv @@
// ----------------------------------------------------------------------------
// mcqe_slot_ram
// Single-port slot memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module mcqe_slot_ram #(
  parameter int DEPTH = mcqe_pkg::MEM_DEPTH_DEF,
  parameter int WIDTH = mcqe_pkg::DATA_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/multi_circular_queue_engine.sv @@
// ----------------------------------------------------------------------------
// multi_circular_queue_engine
// Several circular FIFOs sharing one slot memory, each in a fixed segment.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake       Payload
//   in_ch    sink       valid / ready   func, queue_id, data_in
//   out_ch   source     valid / ready   status, data_out
//   cfg_*    sink       cfg_we only     cfg_index, cfg_data
//
// One request word is taken every cycle while out_ch does not stall; the response
// passes through the read stage, alongside the single-port slot memory's
// registered read, and then through the output register.
// Reset (synchronous, rst_n low) empties every queue and restores a queue
// count of one and a segment of 256 slots; the slot memory is not cleared.
// When out_ch is stalled, the result and memory read stages hold and in_ch
// drops ready once both are occupied.
//
module multi_circular_queue_engine #(
  parameter int MEM_DEPTH  = mcqe_pkg::MEM_DEPTH_DEF,
  parameter int MAX_QUEUES = mcqe_pkg::MAX_QUEUES_DEF,
  parameter int DATA_WIDTH = mcqe_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mcqe_in_if.sink                           in_ch,
  mcqe_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mcqe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcqe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW      = $clog2(MEM_DEPTH);
  localparam int QIDX_W  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PROD_W  = mcqe_pkg::QCOUNT_W + mcqe_pkg::SLOTS_W;
  localparam int DEPTH_W = $clog2(MEM_DEPTH + 1);
  localparam int CMP_W   = (PROD_W > DEPTH_W) ? PROD_W : DEPTH_W;
  localparam int OW      = mcqe_pkg::OFFSET_W;

  // Configuration registers.
  logic [mcqe_pkg::QCOUNT_W-1:0] queue_count_r;
  logic [mcqe_pkg::SLOTS_W-1:0]  slots_r;

  // Per-queue head and tail offsets, kept in flip-flops so that a register
  // write can clear the offsets of every queue together.
  logic [MAX_QUEUES-1:0][OW-1:0] head_r, head_nxt;
  logic [MAX_QUEUES-1:0][OW-1:0] tail_r, tail_nxt;

  // Memory read stage and output register.
  logic              s1_valid_r;
  mcqe_pkg::status_t s1_status_r;
  logic              s1_deq_ok_r;
  logic              out_valid_r;
  mcqe_pkg::status_t out_status_r;
  logic [DATA_WIDTH-1:0] out_data_r;

  logic                   s1_adv;
  logic                   in_fire;
  logic                   cfg_hit;
  logic [QIDX_W-1:0]      qidx;
  logic [CMP_W-1:0]       seg_end;
  logic [CMP_W-1:0]       seg_base;
  logic                   q_valid;
  logic [OW-1:0]          head_raw, tail_raw, head, tail;
  logic [OW-1:0]          head_next, tail_next;
  logic                   is_full, is_empty;
  logic                   enq_ok, deq_ok;
  mcqe_pkg::status_t      status;
  logic [OW-1:0]          offset;
  logic [AW-1:0]          ram_addr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  // Handshake: the read stage moves on when the output register is free or
  // being emptied, and a request is taken when the read stage can move.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Segment checks. The queue's segment runs from queue_id * slots up to
  // (queue_id + 1) * slots - 1 and must lie inside the memory.
  assign qidx     = QIDX_W'(in_ch.queue_id);
  assign seg_end  = CMP_W'(in_ch.queue_id + 4'd1) * CMP_W'(slots_r);
  assign seg_base = CMP_W'(in_ch.queue_id) * CMP_W'(slots_r);

  assign q_valid = ({1'b0, in_ch.queue_id} < queue_count_r) &&
                   (32'(in_ch.queue_id) < 32'(MAX_QUEUES)) &&
                   (slots_r >= mcqe_pkg::SLOTS_MIN) &&
                   (slots_r <= mcqe_pkg::SLOTS_MAX) &&
                   (seg_end <= CMP_W'(MEM_DEPTH));

  // Offsets beyond the segment read as zero; this only matters if the
  // segment shrank, which also clears them, so it is a safety net.
  assign head_raw  = head_r[qidx];
  assign tail_raw  = tail_r[qidx];
  assign head      = ({1'b0, head_raw} >= slots_r) ? '0 : head_raw;
  assign tail      = ({1'b0, tail_raw} >= slots_r) ? '0 : tail_raw;
  assign head_next = mcqe_pkg::wrap_next(head, slots_r);
  assign tail_next = mcqe_pkg::wrap_next(tail, slots_r);
  assign is_full   = (tail_next == head);
  assign is_empty  = (head == tail);

  always_comb begin
    if (!q_valid) begin
      status = mcqe_pkg::ST_INVALID;
    end else if (in_ch.func == mcqe_pkg::FUNC_ENQ) begin
      status = is_full ? mcqe_pkg::ST_FULL : mcqe_pkg::ST_OK;
    end else begin
      status = is_empty ? mcqe_pkg::ST_EMPTY : mcqe_pkg::ST_OK;
    end
  end

  assign enq_ok = in_fire && (status == mcqe_pkg::ST_OK) &&
                  (in_ch.func == mcqe_pkg::FUNC_ENQ);
  assign deq_ok = in_fire && (status == mcqe_pkg::ST_OK) &&
                  (in_ch.func == mcqe_pkg::FUNC_DEQ);

  // An enqueue writes at the tail, a dequeue reads at the head; both lie
  // inside the memory once the segment check has passed.
  assign offset   = (in_ch.func == mcqe_pkg::FUNC_DEQ) ? head : tail;
  assign ram_addr = AW'(seg_base + CMP_W'(offset));

  mcqe_slot_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (enq_ok),
    .re    (deq_ok),
    .addr  (ram_addr),
    .wdata (in_ch.data_in),
    .rdata (ram_rdata)
  );

  // Offset updates. A register write to either listed register empties
  // every queue; the memory contents stay.
  assign cfg_hit = cfg_we && ((cfg_index == mcqe_pkg::CFG_QUEUE_COUNT) ||
                              (cfg_index == mcqe_pkg::CFG_SLOTS));

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cfg_hit) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (enq_ok) begin
        tail_nxt[qidx] = tail_next;
      end
      if (deq_ok) begin
        head_nxt[qidx] = head_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_count_r <= mcqe_pkg::QCOUNT_RST;
      slots_r       <= mcqe_pkg::SLOTS_RST;
      head_r        <= '0;
      tail_r        <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mcqe_pkg::CFG_QUEUE_COUNT: begin
            queue_count_r <= cfg_data[mcqe_pkg::QCOUNT_W-1:0];
          end
          mcqe_pkg::CFG_SLOTS: begin
            slots_r <= cfg_data[mcqe_pkg::SLOTS_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Read stage: holds the status while the memory read completes. The
  // memory's read register only loads on a new dequeue, so it holds too.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= status;
      s1_deq_ok_r <= deq_ok;
    end
  end

  // Output register: the dequeued word is shown only on a successful dequeue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_data_r   <= s1_deq_ok_r ? ram_rdata : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.data_out = out_data_r;

`ifndef SYNTHESIS
  // A response that is not ok never carries data.
  a_nok_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != mcqe_pkg::ST_OK) |-> (out_data_r == '0))
    else $error("non-ok response carries data");

  // A write to either listed configuration register leaves every queue empty.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (head_r == '0) && (tail_r == '0))
    else $error("offsets not cleared by register write");

  // A request that fails, with no such register write beside it, leaves all offsets as they were.
  a_fail_keeps_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_hit && (status != mcqe_pkg::ST_OK) |=>
      $stable(head_r) && $stable(tail_r))
    else $error("failed request changed offsets");
`endif

endmodule
